// ===== hdl/arxpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// arxpc_pkg
// Shared types, round constants, a rotation table, rotation helpers and the round function of
// the ARX rotational pair checker.
// ============================================================================
package arxpc_pkg;

    localparam int WORD_W     = 32;
    localparam int ROT_W      = 5;
    localparam int TBL_ROUNDS = 12;
    localparam int RIDX_W     = 4;
    localparam int CFG_IDX_W  = 3;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CONST_SET      = 3'd0,
        REG_RX_ROTATION    = 3'd1,
        REG_IN_DIFF_LEFT   = 3'd2,
        REG_IN_DIFF_RIGHT  = 3'd3,
        REG_OUT_DIFF_LEFT  = 3'd4,
        REG_OUT_DIFF_RIGHT = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic             const_set;
        logic [ROT_W-1:0] rx_rotation;
        word_t            in_diff_left;
        word_t            in_diff_right;
        word_t            out_diff_left;
        word_t            out_diff_right;
    } cfg_t;

    typedef struct packed {
        word_t l;
        word_t r;
        word_t pl;
        word_t pr;
    } lanes_t;

    localparam logic             RST_CONST_SET      = 1'b0;
    localparam logic [ROT_W-1:0] RST_RX_ROTATION    = 5'd3;
    localparam word_t            RST_IN_DIFF_LEFT   = 32'h7fff_fff8;
    localparam word_t            RST_IN_DIFF_RIGHT  = 32'h3fff_fffe;
    localparam word_t            RST_OUT_DIFF_LEFT  = 32'hb989_d417;
    localparam word_t            RST_OUT_DIFF_RIGHT = 32'h0347_a2a9;

    localparam word_t RC_TABLE [2][TBL_ROUNDS][2] = '{
        '{
            '{32'h00000000, 32'h4e381c1c}, '{32'h2aaaaaaa, 32'h36dbe492},
            '{32'h7fffffff, 32'h1236db6c}, '{32'h55555555, 32'h0763638e},
            '{32'h2aaaaaaa, 32'h1b6d4949}, '{32'h55555555, 32'h638ef1c7},
            '{32'h00000000, 32'h47638e39}, '{32'h2aaaaaaa, 32'h5236b6db},
            '{32'h55555555, 32'h4e381c1c}, '{32'h7fffffff, 32'h638eb1c7},
            '{32'h7fffffff, 32'h47638e39}, '{32'h3f2bb31e, 32'hb6c004cc}
        },
        '{
            '{32'h1c71c924, 32'h249cad47}, '{32'h49249c71, 32'h1249871c},
            '{32'h6db6c71c, 32'h5b127ffe}, '{32'h38e39249, 32'h152ad249},
            '{32'h638e36db, 32'h649cad55}, '{32'h1c71c7ff, 32'h471c9492},
            '{32'h36db6d55, 32'h63f1c71d}, '{32'h471c7249, 32'h36a4ff1c},
            '{32'h4924938e, 32'h5b6c8e47}, '{32'h2aab6db6, 32'h71c736db},
            '{32'h6db638e3, 32'h55b9c71d}, '{32'hfb3d2330, 32'hb6da4b61}
        }
    };

    localparam logic [ROT_W-1:0] ROT_TABLE [4][2] = '{
        '{5'd31, 5'd24}, '{5'd17, 5'd17}, '{5'd0, 5'd31}, '{5'd24, 5'd16}
    };

    function automatic word_t rot_r(input word_t w, input logic [ROT_W-1:0] k);
        logic [2*WORD_W-1:0] d;
        d = {w, w} >> k;
        return d[WORD_W-1:0];
    endfunction

    function automatic word_t rot_l(input word_t w, input logic [ROT_W-1:0] k);
        logic [2*WORD_W-1:0] d;
        d = {w, w} << k;
        return d[2*WORD_W-1:WORD_W];
    endfunction

    function automatic logic [2*WORD_W-1:0] alz_round(
        input word_t             x,
        input word_t             y,
        input logic              set,
        input logic [RIDX_W-1:0] idx
    );
        word_t x1;
        word_t y1;
        x1 = x + rot_r(y, ROT_TABLE[idx[1:0]][0]);
        y1 = y ^ rot_r(x1, ROT_TABLE[idx[1:0]][1]);
        return {x1 ^ RC_TABLE[set][idx][0], y1 ^ RC_TABLE[set][idx][1]};
    endfunction

endpackage
`default_nettype wire

// ===== hdl/arxpc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// arxpc_if
// Valid/ready channels for candidate requests and checker results.
// ============================================================================
interface arxpc_cand_if;
    logic        valid;
    logic        ready;
    logic [31:0] left_in;
    logic [31:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface arxpc_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] left_out;
    logic [31:0] right_out;
    logic        pair_match;

    modport source (output valid, output left_out, output right_out,
                    output pair_match, input ready);
    modport sink (input valid, input left_out, input right_out,
                  input pair_match, output ready);
endinterface
`default_nettype wire

// ===== hdl/arx_rx_pair_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: one entry stage, one stage per round, and one compare and output stage
// lie between an accepted request and its valid result.
// Throughput: one request per cycle while results are taken; each stage moves on when the next one frees up.
// Reset clears all valid bits and loads the configuration defaults at once.
// ============================================================================
// arx_rx_pair_checker
// Pipelined ARX permutation that checks a rotational-differential pair.
// ============================================================================
module arx_rx_pair_checker #(
    parameter int NUM_ROUNDS = 12
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    arxpc_cand_if.sink                            cand,
    arxpc_result_if.source                        result,
    input  wire logic                             wr_en,
    input  wire logic [arxpc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [arxpc_pkg::WORD_W-1:0]     wr_data
);
    import arxpc_pkg::*;

    cfg_t   cfg;
    logic   valid_chain [NUM_ROUNDS+1];
    logic   ready_chain [NUM_ROUNDS+1];
    lanes_t data_chain  [NUM_ROUNDS+1];

    logic   s0_valid_reg;
    logic   s0_valid_next;
    lanes_t s0_data_next;
    lanes_t s0_data_reg;
    logic   s0_load;

    logic   out_valid_reg;
    logic   out_valid_next;
    word_t  left_out_reg;
    word_t  right_out_reg;
    logic   match_reg;
    logic   match_next;
    logic   out_load;
    lanes_t fin;

    arxpc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    assign cand.ready = !s0_valid_reg || ready_chain[0];
    assign s0_load    = cand.valid && cand.ready;

    always_comb
    begin
        s0_valid_next   = cand.ready ? cand.valid : s0_valid_reg;
        s0_data_next.l  = cand.left_in;
        s0_data_next.r  = cand.right_in;
        s0_data_next.pl = rot_l(cand.left_in, cfg.rx_rotation) ^ cfg.in_diff_left;
        s0_data_next.pr = rot_l(cand.right_in, cfg.rx_rotation) ^ cfg.in_diff_right;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_load)
        begin
            s0_data_reg <= s0_data_next;
        end
    end

    assign valid_chain[0] = s0_valid_reg;
    assign data_chain[0]  = s0_data_reg;

    for (genvar g = 0; g < NUM_ROUNDS; g++)
    begin : g_round
        arxpc_round #(
            .ROUND (g)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .const_set (cfg.const_set),
            .up_valid  (valid_chain[g]),
            .up_ready  (ready_chain[g]),
            .up_data   (data_chain[g]),
            .dn_valid  (valid_chain[g+1]),
            .dn_ready  (ready_chain[g+1]),
            .dn_data   (data_chain[g+1])
        );
    end

    assign fin                     = data_chain[NUM_ROUNDS];
    assign ready_chain[NUM_ROUNDS] = !out_valid_reg || result.ready;
    assign out_load                = valid_chain[NUM_ROUNDS] && ready_chain[NUM_ROUNDS];

    always_comb
    begin
        out_valid_next = ready_chain[NUM_ROUNDS] ? valid_chain[NUM_ROUNDS] : out_valid_reg;
        match_next     = (fin.pl == (rot_l(fin.l, cfg.rx_rotation) ^ cfg.out_diff_left))
                      && (fin.pr == (rot_l(fin.r, cfg.rx_rotation) ^ cfg.out_diff_right));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            left_out_reg  <= fin.l;
            right_out_reg <= fin.r;
            match_reg     <= match_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.left_out   = left_out_reg;
    assign result.right_out  = right_out_reg;
    assign result.pair_match = match_reg;

endmodule
`default_nettype wire

// ===== hdl/arxpc_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// arxpc_cfg
// Configuration register file written through a plain indexed write port.
// ============================================================================
module arxpc_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             wr_en,
    input  wire logic [arxpc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [arxpc_pkg::WORD_W-1:0]     wr_data,
    output arxpc_pkg::cfg_t                       cfg
);
    import arxpc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_index))
                REG_CONST_SET:      cfg_next.const_set      = wr_data[0];
                REG_RX_ROTATION:    cfg_next.rx_rotation    = wr_data[ROT_W-1:0];
                REG_IN_DIFF_LEFT:   cfg_next.in_diff_left   = wr_data;
                REG_IN_DIFF_RIGHT:  cfg_next.in_diff_right  = wr_data;
                REG_OUT_DIFF_LEFT:  cfg_next.out_diff_left  = wr_data;
                REG_OUT_DIFF_RIGHT: cfg_next.out_diff_right = wr_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.const_set      <= RST_CONST_SET;
            cfg_reg.rx_rotation    <= RST_RX_ROTATION;
            cfg_reg.in_diff_left   <= RST_IN_DIFF_LEFT;
            cfg_reg.in_diff_right  <= RST_IN_DIFF_RIGHT;
            cfg_reg.out_diff_left  <= RST_OUT_DIFF_LEFT;
            cfg_reg.out_diff_right <= RST_OUT_DIFF_RIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== hdl/arxpc_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// arxpc_round
// One pipeline stage that applies one ARX round to both the candidate lane
// and the rotational pair lane.
// ============================================================================
module arxpc_round #(
    parameter int ROUND = 0
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              const_set,
    input  wire logic              up_valid,
    output logic                   up_ready,
    input  arxpc_pkg::lanes_t      up_data,
    output logic                   dn_valid,
    input  wire logic              dn_ready,
    output arxpc_pkg::lanes_t      dn_data
);
    import arxpc_pkg::*;

    localparam logic [RIDX_W-1:0] RIDX = RIDX_W'(ROUND);

    logic   valid_reg;
    logic   valid_next;
    lanes_t data_reg;
    lanes_t data_next;
    logic   load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        valid_next = up_ready ? up_valid : valid_reg;
        {data_next.l, data_next.r}   = alz_round(up_data.l, up_data.r, const_set, RIDX);
        {data_next.pl, data_next.pr} = alz_round(up_data.pl, up_data.pr, const_set, RIDX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule
`default_nettype wire

// ===== hdl/arxpc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// arxpc_checker
// Port-level checks of the pair checker, bound to the top level.
// ============================================================================
module arxpc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cand_valid,
    input wire logic        cand_ready,
    input wire logic        result_valid,
    input wire logic        result_ready,
    input wire logic [31:0] left_out,
    input wire logic [31:0] right_out,
    input wire logic        pair_match
);

    // A result that is not taken stays offered.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result request dropped while stalled");

    // A stalled result keeps its payload.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable({left_out, right_out, pair_match}))
        else $error("result payload changed while stalled");

    // The pipeline only refuses a request when it is full and the output is stalled.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        cand_valid && !cand_ready |-> result_valid && !result_ready)
        else $error("request refused while the pipeline had room");

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result offered during reset");

endmodule

bind arx_rx_pair_checker arxpc_checker u_arxpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cand_valid   (cand.valid),
    .cand_ready   (cand.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .left_out     (result.left_out),
    .right_out    (result.right_out),
    .pair_match   (result.pair_match)
);
`default_nettype wire
